### rtl/aitc_pkg.sv
// Package for the assist idle-timeout controller.
// Holds the beat types, register map constants and state types shared by all files but the checker.
// No dependencies.
`timescale 1ns / 1ps

package aitc_pkg;

   // Configuration register map (byte address bit 2 selects the register).
   localparam int unsigned CsrAddrWidth = 3;
   localparam logic [0:0] RegIdleTimeout  = 1'b0;
   localparam logic [0:0] RegStepInterval = 1'b1;

   // Register reset values.
   localparam logic [31:0] IdleTimeoutReset  = 32'd600000;
   localparam logic [15:0] StepIntervalReset = 16'd200;

   // Request kinds.
   localparam logic ReqPoll  = 1'b0;
   localparam logic ReqForce = 1'b1;

   // One input beat.
   typedef struct packed {
      logic        req_type;
      logic [31:0] now_ms;
      logic [15:0] wheel_pulses;
      logic        brake_front;
      logic        brake_rear;
      logic [7:0]  assist_setting;
      logic        link_connected;
      logic        timeout_enabled;
   } req_item_type;

   // One result beat.
   typedef struct packed {
      logic send_decrement;
      logic firing_now;
      logic latched_now;
      logic forcing_now;
   } rsp_item_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [31:0] idle_timeout_ms;
      logic [15:0] step_interval_ms;
   } cfg_type;

   // Controller state carried from one beat to the next.
   typedef struct packed {
      logic [31:0] last_activity_time;
      logic [31:0] last_step_time;
      logic [7:0]  seen_assist;
      logic        firing_flag;
      logic        latched_flag;
      logic        forcing_flag;
   } state_type;

endpackage

### rtl/aitc_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on aitc_pkg for the beat types.
`timescale 1ns / 1ps

interface aitc_req_if;
   logic                  valid;
   logic                  ready;
   aitc_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface aitc_rsp_if;
   logic                  valid;
   logic                  ready;
   aitc_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

### rtl/aitc_csr.sv
// APB-style configuration registers: idle timeout and step interval.
// Depends on aitc_pkg for the register map and reset values.
`timescale 1ns / 1ps

module aitc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aitc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output aitc_pkg::cfg_type                 cfg
);

   logic [31:0] idle_timeout_ff;
   logic [31:0] idle_timeout_in;
   logic [15:0] step_interval_ff;
   logic [15:0] step_interval_in;
   logic        wr_strobe;
   logic [0:0]  reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2:2];
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Next register values on a write access.
   always_comb begin
      idle_timeout_in  = idle_timeout_ff;
      step_interval_in = step_interval_ff;
      if (wr_strobe) begin
         case (reg_sel)
            aitc_pkg::RegIdleTimeout:  idle_timeout_in  = csr_pwdata;
            aitc_pkg::RegStepInterval: step_interval_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff  <= aitc_pkg::IdleTimeoutReset;
         step_interval_ff <= aitc_pkg::StepIntervalReset;
      end else begin
         idle_timeout_ff  <= idle_timeout_in;
         step_interval_ff <= step_interval_in;
      end
   end

   // Read back.
   always_comb begin
      case (reg_sel)
         aitc_pkg::RegIdleTimeout:  csr_prdata = idle_timeout_ff;
         aitc_pkg::RegStepInterval: csr_prdata = {16'd0, step_interval_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign cfg.idle_timeout_ms  = idle_timeout_ff;
   assign cfg.step_interval_ms = step_interval_ff;

endmodule

### rtl/aitc_step.sv
// Combinational step logic: next controller state and the result for one beat.
// Depends on aitc_pkg for the beat, state and configuration types.
`timescale 1ns / 1ps

module aitc_step (
   input  aitc_pkg::state_type    state_cur,
   input  aitc_pkg::req_item_type item,
   input  aitc_pkg::cfg_type      cfg,
   output aitc_pkg::state_type    state_nxt,
   output aitc_pkg::rsp_item_type result
);

   logic [31:0] step_elapsed;
   logic [31:0] idle_elapsed;
   logic        step_due;
   logic        idle_due;
   logic        moving;
   logic        braking;
   logic        rise;
   logic        assist_zero;
   logic        pulse;

   // Elapsed times wrap modulo 2^32.
   assign step_elapsed = item.now_ms - state_cur.last_step_time;
   assign idle_elapsed = item.now_ms - state_cur.last_activity_time;
   assign step_due     = item.link_connected && (step_elapsed >= {16'd0, cfg.step_interval_ms});
   assign idle_due     = idle_elapsed >= cfg.idle_timeout_ms;
   assign moving       = item.wheel_pulses != 16'd0;
   assign braking      = item.brake_front || item.brake_rear;
   assign rise         = item.assist_setting > state_cur.seen_assist;
   assign assist_zero  = item.assist_setting == 8'd0;

   // Decision tree, highest priority first: force request, forced drop, disabled,
   // activity, latched, firing, and finally the idle-timeout start check.
   always_comb begin
      state_nxt = state_cur;
      pulse     = 1'b0;
      if (item.req_type == aitc_pkg::ReqForce) begin
         state_nxt.forcing_flag   = 1'b1;
         state_nxt.last_step_time = 32'd0;
      end else if (state_cur.forcing_flag) begin
         if (assist_zero) begin
            state_nxt.forcing_flag = 1'b0;
         end else if (step_due) begin
            state_nxt.last_step_time = item.now_ms;
            pulse                    = 1'b1;
         end
      end else if (!item.timeout_enabled) begin
         state_nxt.last_activity_time = item.now_ms;
         state_nxt.firing_flag        = 1'b0;
         state_nxt.latched_flag       = 1'b0;
      end else begin
         state_nxt.seen_assist = item.assist_setting;
         if (moving || braking || rise) begin
            state_nxt.last_activity_time = item.now_ms;
            state_nxt.firing_flag        = 1'b0;
            state_nxt.latched_flag       = 1'b0;
         end else if (state_cur.latched_flag) begin
            // Already at zero; wait for activity.
         end else if (state_cur.firing_flag) begin
            if (assist_zero) begin
               state_nxt.firing_flag  = 1'b0;
               state_nxt.latched_flag = 1'b1;
            end else if (step_due) begin
               state_nxt.last_step_time = item.now_ms;
               pulse                    = 1'b1;
            end
         end else if (idle_due && !assist_zero && item.link_connected) begin
            state_nxt.firing_flag    = 1'b1;
            state_nxt.last_step_time = 32'd0;
         end
      end
   end

   assign result.send_decrement = pulse;
   assign result.firing_now     = state_nxt.firing_flag;
   assign result.latched_now    = state_nxt.latched_flag;
   assign result.forcing_now    = state_nxt.forcing_flag;

endmodule

### rtl/assist_idle_timeout_controller.sv
// Top level of the assist idle-timeout controller.
// Depends on aitc_pkg, aitc_if, aitc_csr and aitc_step.
`timescale 1ns / 1ps

// The controller takes one request beat per clock cycle unless stalled and returns
// exactly one result beat for each, in order. A beat is held in the input register and
// is evaluated against the controller state as it moves into the result register, from
// which it is presented; the state is updated in the same cycle, so the following beat
// is evaluated against the updated state. The request side keeps accepting while a
// result waits, stalling only when both the input and result registers are full and the
// result is not taken in that cycle. The idle timeout and the pacing interval are to be
// written through the configuration port only while the stream is idle; the user must
// keep to this, as the block itself does not enforce it. There is no clearing pass
// after reset.
module assist_idle_timeout_controller (
   input  logic                              clock,
   input  logic                              reset,
   aitc_req_if.sink                          req_bus,
   aitc_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aitc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   aitc_pkg::cfg_type      cfg;
   aitc_pkg::state_type    state_ff;
   aitc_pkg::state_type    state_in;
   aitc_pkg::req_item_type in_item_ff;
   aitc_pkg::rsp_item_type out_item_ff;
   aitc_pkg::rsp_item_type step_result;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   advance;
   logic                   req_take;

   aitc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aitc_step u_step (
      .state_cur (state_ff),
      .item      (in_item_ff),
      .cfg       (cfg),
      .state_nxt (state_in),
      .result    (step_result)
   );

   // Handshake: the held beat moves on when the result register is free or drains.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_bus.item;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.item  = out_item_ff;

endmodule

### rtl/aitc_checker.sv
// Port-level assertions for the assist idle-timeout controller, bound to the top level.
// Depends on aitc_pkg only through the top level it is bound to.
`timescale 1ns / 1ps

module aitc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic send_decrement,
   input logic firing_now,
   input logic latched_now,
   input logic forcing_now
);

   // A decrement is only requested during a timeout step-down or a forced drop.
   a_pulse_needs_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && send_decrement) |-> (firing_now || forcing_now))
      else $error("decrement beat without firing or forcing");

   // Firing and latched are mutually exclusive.
   a_fire_latch_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(firing_now && latched_now))
      else $error("firing and latched both set");

   // A latched controller never asks for a decrement outside a forced drop.
   a_latched_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && latched_now && !forcing_now) |-> !send_decrement)
      else $error("decrement while latched");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(send_decrement)
         && $stable(firing_now) && $stable(latched_now) && $stable(forcing_now)))
      else $error("result beat changed while stalled");

endmodule

bind assist_idle_timeout_controller aitc_checker u_aitc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .send_decrement (rsp_bus.item.send_decrement),
   .firing_now     (rsp_bus.item.firing_now),
   .latched_now    (rsp_bus.item.latched_now),
   .forcing_now    (rsp_bus.item.forcing_now)
);

### tb/sv/assist_idle_timeout_controller_test.sv
// Self-checking testbench for the assist idle-timeout controller.
// Drives poll and force beats with random gaps, predicts every result and checks it.
// Depends on aitc_pkg, aitc_if and the assist_idle_timeout_controller RTL.
`timescale 1ns / 1ps

module assist_idle_timeout_controller_test;

   // One row of the directed stimulus; want is only used where typed is set.
   typedef struct {
      aitc_pkg::req_item_type beat;
      bit                     typed;
      aitc_pkg::rsp_item_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [aitc_pkg::CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   aitc_req_if req_if ();
   aitc_rsp_if rsp_if ();

   assist_idle_timeout_controller DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor copy of the controller state and registers.
   aitc_pkg::state_type    ctl_state;
   aitc_pkg::cfg_type      ctl_cfg;
   aitc_pkg::rsp_item_type expected_rsp_q[$];
   directed_row_type       directed_rows[$];

   // Rider model used to shape the random stream.
   logic [31:0] ride_time_ms;
   logic [7:0]  motor_assist;
   logic        last_pulse;

   int  failures;
   int  beats_sent;
   int  pulses_predicted;
   int  forced_requests;
   int  settings_used;
   int  rsp_hold = 0;
   bit  no_idle;
   bit  stall_request;
   bit  stall_active;

   always #6 clock = ~clock;

   // Report a failure; only the first ten are printed.
   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // Paced decrement: at most one pulse per step interval, only with the link up.
   function automatic logic pace_decrement(input logic [31:0] now, input logic link);
      logic [31:0] since_step;
      since_step = now - ctl_state.last_step_time;
      if (link && since_step >= {16'd0, ctl_cfg.step_interval_ms}) begin
         ctl_state.last_step_time = now;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Work out the result of one accepted beat and advance the predicted state.
   function automatic aitc_pkg::rsp_item_type predict_beat(input aitc_pkg::req_item_type b);
      aitc_pkg::rsp_item_type r;
      logic                   pulse;
      logic                   rise;
      logic [31:0]            idle_for;
      pulse = 1'b0;
      if (b.req_type == aitc_pkg::ReqForce) begin
         ctl_state.forcing_flag   = 1'b1;
         ctl_state.last_step_time = 32'd0;
      end else if (ctl_state.forcing_flag) begin
         // A forced drop ignores everything but assist, link and time.
         if (b.assist_setting == 8'd0) ctl_state.forcing_flag = 1'b0;
         else pulse = pace_decrement(b.now_ms, b.link_connected);
      end else if (!b.timeout_enabled) begin
         ctl_state.last_activity_time = b.now_ms;
         ctl_state.firing_flag        = 1'b0;
         ctl_state.latched_flag       = 1'b0;
      end else begin
         rise = b.assist_setting > ctl_state.seen_assist;
         ctl_state.seen_assist = b.assist_setting;
         idle_for = b.now_ms - ctl_state.last_activity_time;
         if (b.wheel_pulses != 16'd0 || b.brake_front || b.brake_rear || rise) begin
            ctl_state.last_activity_time = b.now_ms;
            ctl_state.firing_flag        = 1'b0;
            ctl_state.latched_flag       = 1'b0;
         end else if (!ctl_state.latched_flag) begin
            if (ctl_state.firing_flag) begin
               if (b.assist_setting == 8'd0) begin
                  ctl_state.firing_flag  = 1'b0;
                  ctl_state.latched_flag = 1'b1;
               end else begin
                  pulse = pace_decrement(b.now_ms, b.link_connected);
               end
            end else if (idle_for >= ctl_cfg.idle_timeout_ms && b.assist_setting != 8'd0 &&
                         b.link_connected) begin
               // Firing starts without a pulse in the same poll.
               ctl_state.firing_flag    = 1'b1;
               ctl_state.last_step_time = 32'd0;
            end
         end
      end
      r.send_decrement = pulse;
      r.firing_now     = ctl_state.firing_flag;
      r.latched_now    = ctl_state.latched_flag;
      r.forcing_now    = ctl_state.forcing_flag;
      return r;
   endfunction

   function automatic aitc_pkg::req_item_type poll_beat(input logic [31:0] now,
                                                        input logic [15:0] wheel,
                                                        input logic fb, input logic rb,
                                                        input logic [7:0] assist,
                                                        input logic link,
                                                        input logic en);
      aitc_pkg::req_item_type b;
      b.req_type        = aitc_pkg::ReqPoll;
      b.now_ms          = now;
      b.wheel_pulses    = wheel;
      b.brake_front     = fb;
      b.brake_rear      = rb;
      b.assist_setting  = assist;
      b.link_connected  = link;
      b.timeout_enabled = en;
      return b;
   endfunction

   task automatic add_row(input aitc_pkg::req_item_type b, input bit typed,
                          input aitc_pkg::rsp_item_type want);
      directed_row_type row;
      row.beat  = b;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // One APB transfer: setup cycle, access cycle, done when pready is seen.
   task automatic csr_access(input logic [0:0] reg_sel, input logic write,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_register(input logic [0:0] reg_sel, input logic [31:0] want);
      logic [31:0] got;
      csr_access(reg_sel, 1'b0, 32'd0, got);
      if (got !== want)
         note_failure($sformatf("register %0d reads %h, expected %h", reg_sel, got, want));
   endtask

   task automatic program_register(input logic [0:0] reg_sel, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(reg_sel, 1'b1, value, unused);
      if (reg_sel == aitc_pkg::RegIdleTimeout) ctl_cfg.idle_timeout_ms = value;
      else ctl_cfg.step_interval_ms = value[15:0];
      check_register(reg_sel,
                     (reg_sel == aitc_pkg::RegIdleTimeout) ? value : {16'd0, value[15:0]});
   endtask

   // Offer one beat after an optional gap and record its expected result on acceptance.
   task automatic send_beat(input aitc_pkg::req_item_type b, input bit typed,
                            input aitc_pkg::rsp_item_type want);
      aitc_pkg::rsp_item_type predicted;
      int unsigned            pick;
      int                     gap;
      gap = 0;
      if (!no_idle && !stall_active) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95) gap = $urandom_range(8, 40);
         else if (pick >= 65) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.item  <= b;
      do @(posedge clock); while (!req_if.ready);
      predicted = predict_beat(b);
      expected_rsp_q.push_back(typed ? want : predicted);
      last_pulse = predicted.send_decrement;
      beats_sent++;
      if (predicted.send_decrement) pulses_predicted++;
      if (b.req_type == aitc_pkg::ReqForce) forced_requests++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_results;
      req_if.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Next beat of a ride: time moves on, the motor follows pulses, activity is sparse.
   task automatic make_ride_beat(output aitc_pkg::req_item_type b);
      int unsigned pick;
      int unsigned idle_cap;
      logic [31:0] rnd;
      rnd = $urandom;
      if ($urandom_range(0, 99) < 3) begin
         // Force requests carry random junk in every other field.
         b.req_type        = aitc_pkg::ReqForce;
         b.now_ms          = $urandom;
         b.wheel_pulses    = rnd[15:0];
         b.assist_setting  = rnd[23:16];
         b.brake_front     = rnd[24];
         b.brake_rear      = rnd[25];
         b.link_connected  = rnd[26];
         b.timeout_enabled = rnd[27];
      end else begin
         if (last_pulse && motor_assist != 8'd0) motor_assist = motor_assist - 8'd1;
         idle_cap = (ctl_cfg.idle_timeout_ms > 32'd2000000) ? 2000000 :
                    int'(ctl_cfg.idle_timeout_ms);
         pick = $urandom_range(0, 99);
         if (pick < 4) ride_time_ms = $urandom;
         else if (pick < 15) ride_time_ms = ride_time_ms;
         else if (pick < 75)
            ride_time_ms = ride_time_ms + $urandom_range(0, int'(ctl_cfg.step_interval_ms) + 8);
         else ride_time_ms = ride_time_ms + $urandom_range(0, idle_cap / 2 + 1);
         pick = $urandom_range(0, 99);
         if (pick < 5) motor_assist = (motor_assist > 8'd252) ? 8'd255 : motor_assist + 8'd3;
         else if (pick < 7) motor_assist = rnd[7:0];
         else if (pick < 9) motor_assist = 8'd0;
         b.req_type        = aitc_pkg::ReqPoll;
         b.now_ms          = ride_time_ms;
         b.wheel_pulses    = ($urandom_range(0, 99) < 6) ? 16'($urandom_range(1, 65535)) :
                             16'd0;
         b.brake_front     = $urandom_range(0, 99) < 3;
         b.brake_rear      = $urandom_range(0, 99) < 3;
         b.assist_setting  = motor_assist;
         b.link_connected  = $urandom_range(0, 99) >= 8;
         b.timeout_enabled = $urandom_range(0, 99) >= 4;
      end
   endtask

   // Result side readiness: random short and long hold-offs, plus the long stall.
   always @(negedge clock) begin
      if (stall_active) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 99) < 20)
            rsp_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                       $urandom_range(1, 3);
      end
   end

   // Long receiver stall so that the block fills up and pushes back on the sender.
   initial begin
      stall_active = 1'b0;
      wait (stall_request);
      @(negedge clock);
      stall_active <= 1'b1;
      repeat (60) @(negedge clock);
      stall_active <= 1'b0;
   end

   // Compare every result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp_q.size() == 0) begin
            note_failure($sformatf("result beat %b with nothing expected", rsp_if.item));
         end else begin
            automatic aitc_pkg::rsp_item_type want = expected_rsp_q.pop_front();
            automatic aitc_pkg::rsp_item_type got  = rsp_if.item;
            if (got.send_decrement !== want.send_decrement ||
                got.firing_now !== want.firing_now ||
                got.latched_now !== want.latched_now ||
                got.forcing_now !== want.forcing_now)
               note_failure($sformatf(
                  "mismatch: expected dec=%b fire=%b latch=%b force=%b, got %b %b %b %b",
                  want.send_decrement, want.firing_now, want.latched_now, want.forcing_now,
                  got.send_decrement, got.firing_now, got.latched_now, got.forcing_now));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("[assist_idle_timeout_controller] ERROR");
      $finish;
   end

   initial begin
      aitc_pkg::req_item_type b;
      logic [31:0]            idle_value;
      logic [31:0]            step_value;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.item    = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = 32'd0;
      ctl_state      = '0;
      ctl_cfg.idle_timeout_ms  = aitc_pkg::IdleTimeoutReset;
      ctl_cfg.step_interval_ms = aitc_pkg::StepIntervalReset;
      ride_time_ms   = 32'd0;
      motor_assist   = 8'd0;
      last_pulse     = 1'b0;
      failures       = 0;
      beats_sent     = 0;
      pulses_predicted = 0;
      forced_requests  = 0;
      settings_used  = 1;
      no_idle        = 1'b0;
      stall_request  = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_register(aitc_pkg::RegIdleTimeout, aitc_pkg::IdleTimeoutReset);
      check_register(aitc_pkg::RegStepInterval, {16'd0, aitc_pkg::StepIntervalReset});

      // Directed rows under reset registers; typed results are send, firing, latched,
      // forcing from left to right.
      add_row(poll_beat(32'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1), 1'b1, 4'b0000);
      add_row(poll_beat(32'd600000, 16'd0, 1'b0, 1'b0, 8'd5, 1'b1, 1'b1), 1'b1, 4'b0000);
      add_row(poll_beat(32'd1200000, 16'd0, 1'b0, 1'b0, 8'd5, 1'b1, 1'b1), 1'b1, 4'b0100);
      add_row(poll_beat(32'd1200000, 16'd0, 1'b0, 1'b0, 8'd5, 1'b1, 1'b1), 1'b1, 4'b1100);
      add_row(poll_beat(32'd1200100, 16'd0, 1'b0, 1'b0, 8'd4, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd1200300, 16'd0, 1'b0, 1'b0, 8'd4, 1'b0, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd1200300, 16'd0, 1'b0, 1'b0, 8'd4, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd1200400, 16'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd1300000, 16'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd1300000, 16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1), 1'b0, '0);
      // Force request with every other field at its maximum.
      add_row('1, 1'b1, 4'b0001);
      // Forced pacing across the time stamp wrap.
      add_row(poll_beat(32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0, 8'd255, 1'b1, 1'b0), 1'b0, '0);
      add_row(poll_beat(32'd0, 16'd0, 1'b0, 1'b0, 8'd255, 1'b1, 1'b0), 1'b0, '0);
      add_row(poll_beat(32'd199, 16'd0, 1'b0, 1'b0, 8'd255, 1'b1, 1'b0), 1'b0, '0);
      add_row(poll_beat(32'd400, 16'd0, 1'b1, 1'b0, 8'd0, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd500, 16'd0, 1'b0, 1'b0, 8'd9, 1'b1, 1'b0), 1'b1, 4'b0000);
      add_row(poll_beat(32'd600, 16'd0, 1'b1, 1'b0, 8'd9, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd700, 16'd0, 1'b0, 1'b1, 8'd9, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd700, 16'd1, 1'b0, 1'b0, 8'd9, 1'b1, 1'b1), 1'b0, '0);
      b = '0;
      b.req_type = aitc_pkg::ReqForce;
      add_row(b, 1'b1, 4'b0001);
      add_row(poll_beat(32'd100, 16'd0, 1'b0, 1'b0, 8'd3, 1'b0, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd100, 16'd0, 1'b0, 1'b0, 8'd3, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd200, 16'd0, 1'b0, 1'b0, 8'd3, 1'b1, 1'b1), 1'b0, '0);
      add_row(poll_beat(32'd200, 16'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1), 1'b0, '0);
      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      // Random rides under several register settings, extremes first.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin idle_value = 32'd0;         step_value = 32'd0;      end
            1: begin idle_value = 32'hFFFF_FFFF; step_value = 32'hFFFF;   end
            2: begin idle_value = $urandom_range(50, 400); step_value = $urandom_range(1, 40); end
            3: begin idle_value = $urandom_range(0, 30);   step_value = $urandom_range(0, 5);  end
            default: begin
               idle_value = aitc_pkg::IdleTimeoutReset;
               step_value = {16'd0, aitc_pkg::StepIntervalReset};
            end
         endcase
         program_register(aitc_pkg::RegIdleTimeout, idle_value);
         program_register(aitc_pkg::RegStepInterval, step_value);
         settings_used++;
         for (int n = 0; n < 216; n++) begin
            no_idle <= (n < 40);
            if (phase == 2 && n == 100) stall_request = 1'b1;
            make_ride_beat(b);
            send_beat(b, 1'b0, '0);
         end
         no_idle <= 1'b0;
         drain_results();
      end

      repeat (10) @(negedge clock);
      if (expected_rsp_q.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_rsp_q.size()));
      $display("Run covered %0d beats over %0d register settings, %0d of them directed.",
               beats_sent, settings_used, directed_rows.size());
      $display("It saw %0d predicted decrement pulses and %0d force requests; %0d failures.",
               pulses_predicted, forced_requests, failures);
      if (failures == 0) $display("[assist_idle_timeout_controller] OK");
      else $display("[assist_idle_timeout_controller] ERROR");
      $finish;
   end

endmodule

### assist_idle_timeout_controller.f
rtl/aitc_pkg.sv
rtl/aitc_if.sv
rtl/aitc_csr.sv
rtl/aitc_step.sv
rtl/assist_idle_timeout_controller.sv
rtl/aitc_checker.sv
tb/sv/assist_idle_timeout_controller_test.sv
